>>> src/ega_pkg.sv
`timescale 1ns / 1ps

package ega_pkg;

    // Table geometry
    localparam int KEY_SLOTS = 64;
    localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int FILL_W    = $clog2(KEY_SLOTS + 1);
    localparam int KEY_W     = 38;
    localparam int NUM_ARMS  = 3;
    localparam int TRIES_W   = 32;
    localparam int SUM_W     = 48;
    localparam int LAT_W     = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 80;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [1:0]          NO_ARM    = 2'd3;
    localparam logic [15:0]         LFSR_TAPS = 16'hB400;
    localparam logic [TRIES_W-1:0]  TRIES_MAX = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX   = '1;

    // Size band bounds in bytes
    localparam logic [47:0] BAND_1K   = 48'd1024;
    localparam logic [47:0] BAND_16K  = 48'd16384;
    localparam logic [47:0] BAND_256K = 48'd262144;
    localparam logic [47:0] BAND_1M   = 48'd1048576;
    localparam logic [47:0] BAND_8M   = 48'd8388608;

    // Register reset values
    localparam logic [15:0] RST_LOCAL_NODES = 16'd1;
    localparam logic [15:0] RST_LOCAL_RANKS = 16'd1;
    localparam logic [16:0] RST_EXPLORE     = 17'd6554;
    localparam logic [2:0]  RST_ALGO_COUNT  = 3'd7;
    localparam logic [2:0]  RST_PROTO_COUNT = 3'd3;
    localparam logic [15:0] RST_LFSR_SEED   = 16'd44257;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_REWARD = 1'b1;

    typedef enum logic [2:0] {
        ST_CHOSEN         = 3'd0,
        ST_TABLE_FULL     = 3'd1,
        ST_OUT_OF_BOUNDS  = 3'd2,
        ST_IGNORED        = 3'd3,
        ST_REWARD_APPLIED = 3'd4,
        ST_UNKNOWN_KEY    = 3'd5,
        ST_NO_LAST_ARM    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CFG_LOCAL_NODES = 3'd0,
        CFG_LOCAL_RANKS = 3'd1,
        CFG_EXPLORE     = 3'd2,
        CFG_ALGO_COUNT  = 3'd3,
        CFG_PROTO_COUNT = 3'd4,
        CFG_LFSR_SEED   = 3'd5
    } cfg_index_t;

    // Steps of one mean comparison on the shared multiplier
    typedef enum logic [2:0] {
        MSTEP_L_LO  = 3'd0,
        MSTEP_L_HI  = 3'd1,
        MSTEP_R_LO  = 3'd2,
        MSTEP_R_HI  = 3'd3,
        MSTEP_R_ACC = 3'd4,
        MSTEP_CMP   = 3'd5
    } mstep_t;

    typedef struct packed {
        logic   latch;
        logic   search_run;
        logic   add;
        logic   set_full;
        logic   set_unknown;
        logic   row_read;
        logic   reward;
        logic   pick;
        logic   draw2;
        logic   mean_step;
        mstep_t mean_cnt;
        logic   check;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic op_reward;
        logic hit;
        logic miss;
        logic full;
        logic untried;
        logic explore;
        logic cand_last;
    } dp_stat_t;

    function automatic logic [2:0] size_band(input logic [47:0] n);
        logic [2:0] b;
        if (n < BAND_1K)
            b = 3'd0;
        else if (n < BAND_16K)
            b = 3'd1;
        else if (n < BAND_256K)
            b = 3'd2;
        else if (n < BAND_1M)
            b = 3'd3;
        else if (n < BAND_8M)
            b = 3'd4;
        else
            b = 3'd5;
        return b;
    endfunction

    // Galois LFSR, shifting right
    function automatic logic [15:0] lfsr_step(input logic [15:0] r);
        return r[0] ? ((r >> 1) ^ LFSR_TAPS) : (r >> 1);
    endfunction

    // Residue mod 3 from base-4 digit sums, since 4 is 1 mod 3
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        int         i;
        s = '0;
        for (i = 0; i < 8; i++)
            s = s + 5'(v[2*i +: 2]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6)
            t = t - 3'd6;
        else if (t >= 3'd3)
            t = t - 3'd3;
        return t[1:0];
    endfunction

    function automatic logic [2:0] arm_algo(input logic [1:0] arm);
        logic [2:0] a;
        case (arm)
            2'd0:    a = 3'd0;
            2'd1:    a = 3'd0;
            2'd2:    a = 3'd1;
            default: a = 3'd0;
        endcase
        return a;
    endfunction

    function automatic logic [2:0] arm_proto(input logic [1:0] arm);
        logic [2:0] p;
        case (arm)
            2'd0:    p = 3'd2;
            2'd1:    p = 3'd1;
            2'd2:    p = 3'd2;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

>>> src/ega_ifs.sv
`timescale 1ns / 1ps

// Request channel
interface ega_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  coll_type;
    logic [47:0] byte_count;
    logic [15:0] reward_nodes;
    logic [15:0] reward_ranks;
    logic [31:0] latency;
    logic [2:0]  arm_ignore_mask;

    modport source (
        output valid, op, coll_type, byte_count, reward_nodes, reward_ranks,
               latency, arm_ignore_mask,
        input  ready
    );
    modport sink (
        input  valid, op, coll_type, byte_count, reward_nodes, reward_ranks,
               latency, arm_ignore_mask,
        output ready
    );
endinterface

// Response channel
interface ega_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] arm_index;
    logic [2:0] algo_code;
    logic [2:0] proto_code;
    logic [5:0] key_slot;

    modport source (
        output valid, status, arm_index, algo_code, proto_code, key_slot,
        input  ready
    );
    modport sink (
        input  valid, status, arm_index, algo_code, proto_code, key_slot,
        output ready
    );
endinterface

>>> src/ega_datapath.sv
`timescale 1ns / 1ps

module ega_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ega_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ega_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                op,
    input  logic [2:0]                          coll_type,
    input  logic [47:0]                         byte_count,
    input  logic [15:0]                         reward_nodes,
    input  logic [15:0]                         reward_ranks,
    input  logic [31:0]                         latency,
    input  logic [2:0]                          arm_ignore_mask,
    input  ega_pkg::dp_cmd_t                    cmd,
    output ega_pkg::dp_stat_t                   stat,
    output ega_pkg::status_t                    out_status,
    output logic [1:0]                          out_arm,
    output logic [2:0]                          out_algo,
    output logic [2:0]                          out_proto,
    output logic [5:0]                          out_slot
);
    import ega_pkg::*;

    // Configuration and random state
    logic [15:0] local_nodes_reg;
    logic [15:0] local_ranks_reg;
    logic [16:0] explore_reg;
    logic [2:0]  algo_cnt_reg;
    logic [2:0]  proto_cnt_reg;
    logic [15:0] random_reg;

    // Request held for the whole item
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [2:0]       mask_reg;
    logic [LAT_W-1:0] lat_reg;

    // Key table and search
    logic [KEY_W-1:0]  key_mem [KEY_SLOTS];
    logic [KEY_W-1:0]  key_q;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] scan_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Arm rows
    logic [NUM_ARMS*TRIES_W-1:0] tries_mem [KEY_SLOTS];
    logic [NUM_ARMS*SUM_W-1:0]   sums_mem  [KEY_SLOTS];
    logic [1:0]                  last_mem  [KEY_SLOTS];
    logic [NUM_ARMS*TRIES_W-1:0] tries_q;
    logic [NUM_ARMS*SUM_W-1:0]   sums_q;
    logic [1:0]                  last_q;

    // Arm choice and mean comparison
    logic [1:0]        arm_reg;
    logic [1:0]        best_reg;
    logic [1:0]        cand_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  lacc_reg;
    logic [ACC_W-1:0]  racc_reg;

    // Result of the current item and the output register
    status_t           res_status_reg;
    logic [1:0]        res_arm_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    status_t           out_status_reg;
    logic [1:0]        out_arm_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    logic [TRIES_W-1:0]          tries_lane [NUM_ARMS];
    logic [SUM_W-1:0]            sum_lane   [NUM_ARMS];
    logic [KEY_W-1:0]            key_new;
    logic                        issue;
    logic                        hit;
    logic                        full;
    logic                        untried;
    logic [1:0]                  first_untried;
    logic [15:0]                 draw1;
    logic [15:0]                 draw2;
    logic [SLOT_W-1:0]           wr_slot;
    logic [TRIES_W-1:0]          tries_inc;
    logic [SUM_W:0]              sum_add;
    logic [SUM_W-1:0]            sum_sat;
    logic [NUM_ARMS*TRIES_W-1:0] tries_row_new;
    logic [NUM_ARMS*SUM_W-1:0]   sums_row_new;
    logic [31:0]                 mul_a;
    logic [31:0]                 mul_b;
    logic [SUM_W-1:0]            sum_a;
    logic [SUM_W-1:0]            sum_b;
    logic [TRIES_W-1:0]          tries_a;
    logic [TRIES_W-1:0]          tries_b;
    logic                        oob;
    logic                        ign;
    logic                        has_last;

    // Split the row registers into lanes
    always_comb
    begin
        for (int i = 0; i < NUM_ARMS; i++)
        begin
            tries_lane[i] = tries_q[i*TRIES_W +: TRIES_W];
            sum_lane[i]   = sums_q[i*SUM_W +: SUM_W];
        end
    end

    // Key of the incoming request
    always_comb
    begin
        if (op == OP_REWARD)
            key_new = {coll_type, size_band(byte_count), reward_nodes, reward_ranks};
        else
            key_new = {coll_type, size_band(byte_count), local_nodes_reg, local_ranks_reg};
    end

    // Search and status
    assign hit   = rd_valid_reg && (key_q == key_reg);
    assign issue = cmd.search_run && (scan_reg < fill_reg) && !hit;
    assign full  = (fill_reg == FILL_W'(KEY_SLOTS));

    always_comb
    begin
        untried       = 1'b0;
        first_untried = 2'd0;
        for (int i = NUM_ARMS - 1; i >= 0; i--)
        begin
            if (tries_lane[i] == '0)
            begin
                untried       = 1'b1;
                first_untried = 2'(i);
            end
        end
    end

    assign draw1 = lfsr_step(random_reg);
    assign draw2 = lfsr_step(random_reg);

    assign stat.op_reward = op_reg;
    assign stat.hit       = hit;
    assign stat.miss      = !rd_valid_reg && !(scan_reg < fill_reg);
    assign stat.full      = full;
    assign stat.untried   = untried;
    assign stat.explore   = ({1'b0, draw1} < explore_reg);
    assign stat.cand_last = (cand_reg == 2'd2);

    // Reward update of the last arm, saturating
    assign has_last  = (last_q != NO_ARM);
    assign tries_inc = (tries_lane[last_q] == TRIES_MAX) ? TRIES_MAX
                                                        : tries_lane[last_q] + 1'b1;
    assign sum_add   = {1'b0, sum_lane[last_q]} + (SUM_W + 1)'(lat_reg);
    assign sum_sat   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    always_comb
    begin
        tries_row_new = tries_q;
        sums_row_new  = sums_q;
        for (int i = 0; i < NUM_ARMS; i++)
        begin
            if (last_q == 2'(i))
            begin
                tries_row_new[i*TRIES_W +: TRIES_W] = tries_inc;
                sums_row_new[i*SUM_W +: SUM_W]      = sum_sat;
            end
        end
    end

    assign wr_slot = cmd.add ? fill_reg[SLOT_W-1:0] : slot_reg;

    // Multiplier operands: candidate sum against best tries, and the reverse
    assign sum_a   = sum_lane[cand_reg];
    assign sum_b   = sum_lane[best_reg];
    assign tries_a = tries_lane[cand_reg];
    assign tries_b = tries_lane[best_reg];

    always_comb
    begin
        case (cmd.mean_cnt)
            MSTEP_L_LO:
            begin
                mul_a = sum_a[31:0];
                mul_b = tries_b;
            end
            MSTEP_L_HI:
            begin
                mul_a = {16'd0, sum_a[SUM_W-1:32]};
                mul_b = tries_b;
            end
            MSTEP_R_LO:
            begin
                mul_a = sum_b[31:0];
                mul_b = tries_a;
            end
            MSTEP_R_HI:
            begin
                mul_a = {16'd0, sum_b[SUM_W-1:32]};
                mul_b = tries_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Pick checks
    assign oob = (arm_algo(arm_reg) >= algo_cnt_reg) || (arm_proto(arm_reg) >= proto_cnt_reg);
    assign ign = mask_reg[arm_reg];

    // Memories: key table and arm rows
    always_ff @(posedge clk)
    begin
        if (cmd.add)
            key_mem[fill_reg[SLOT_W-1:0]] <= key_reg;
        if (issue)
            key_q <= key_mem[scan_reg[SLOT_W-1:0]];

        if (cmd.add)
        begin
            tries_mem[wr_slot] <= '0;
            sums_mem[wr_slot]  <= '0;
        end
        else if (cmd.reward && has_last)
        begin
            tries_mem[wr_slot] <= tries_row_new;
            sums_mem[wr_slot]  <= sums_row_new;
        end

        if (cmd.add)
            last_mem[wr_slot] <= NO_ARM;
        else if (cmd.check && !oob && !ign)
            last_mem[wr_slot] <= arm_reg;

        if (cmd.row_read)
        begin
            tries_q <= tries_mem[slot_reg];
            sums_q  <= sums_mem[slot_reg];
            last_q  <= last_mem[slot_reg];
        end
        else if (cmd.add)
        begin
            tries_q <= '0;
            sums_q  <= '0;
            last_q  <= NO_ARM;
        end
    end

    // Configuration, random state, table fill and search control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_nodes_reg <= RST_LOCAL_NODES;
            local_ranks_reg <= RST_LOCAL_RANKS;
            explore_reg     <= RST_EXPLORE;
            algo_cnt_reg    <= RST_ALGO_COUNT;
            proto_cnt_reg   <= RST_PROTO_COUNT;
            random_reg      <= RST_LFSR_SEED;
            fill_reg        <= '0;
            scan_reg        <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOCAL_NODES: local_nodes_reg <= cfg_wdata[15:0];
                    CFG_LOCAL_RANKS: local_ranks_reg <= cfg_wdata[15:0];
                    CFG_EXPLORE:     explore_reg     <= cfg_wdata;
                    CFG_ALGO_COUNT:  algo_cnt_reg    <= cfg_wdata[2:0];
                    CFG_PROTO_COUNT: proto_cnt_reg   <= cfg_wdata[2:0];
                    CFG_LFSR_SEED:   random_reg      <= (cfg_wdata[15:0] == 16'd0) ?
                                                        16'd1 : cfg_wdata[15:0];
                    default: ;
                endcase
            end
            else if (cmd.pick && !untried)
                random_reg <= draw1;
            else if (cmd.draw2)
                random_reg <= draw2;

            if (cmd.add)
                fill_reg <= fill_reg + 1'b1;

            if (cmd.latch)
            begin
                scan_reg     <= '0;
                rd_valid_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                    scan_reg <= scan_reg + 1'b1;
                rd_valid_reg <= issue;
            end
        end
    end

    // Item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= op;
            key_reg  <= key_new;
            mask_reg <= arm_ignore_mask;
            lat_reg  <= latency;
        end

        if (issue)
            rd_idx_reg <= scan_reg[SLOT_W-1:0];

        if (cmd.search_run && hit)
            slot_reg <= rd_idx_reg;
        else if (cmd.add)
            slot_reg <= fill_reg[SLOT_W-1:0];

        // Arm choice
        if (cmd.pick)
        begin
            arm_reg  <= first_untried;
            best_reg <= 2'd0;
            cand_reg <= 2'd1;
        end
        else if (cmd.draw2)
            arm_reg <= mod3_16(draw2);

        // Mean comparison on one shared multiplier
        if (cmd.mean_step)
        begin
            prod_reg <= mul_a * mul_b;
            case (cmd.mean_cnt)
                MSTEP_L_HI:  lacc_reg <= ACC_W'(prod_reg);
                MSTEP_R_LO:  lacc_reg <= lacc_reg + {prod_reg[SUM_W-1:0], 32'd0};
                MSTEP_R_HI:  racc_reg <= ACC_W'(prod_reg);
                MSTEP_R_ACC: racc_reg <= racc_reg + {prod_reg[SUM_W-1:0], 32'd0};
                MSTEP_CMP:
                begin
                    if (lacc_reg < racc_reg)
                    begin
                        best_reg <= cand_reg;
                        arm_reg  <= cand_reg;
                    end
                    else
                        arm_reg <= best_reg;
                    cand_reg <= cand_reg + 2'd1;
                end
                default: ;
            endcase
        end

        // Result of the item
        if (cmd.set_unknown)
        begin
            res_status_reg <= ST_UNKNOWN_KEY;
            res_arm_reg    <= NO_ARM;
            res_slot_reg   <= '0;
        end
        else if (cmd.set_full)
        begin
            res_status_reg <= ST_TABLE_FULL;
            res_arm_reg    <= NO_ARM;
            res_slot_reg   <= '0;
        end
        else if (cmd.reward)
        begin
            res_status_reg <= has_last ? ST_REWARD_APPLIED : ST_NO_LAST_ARM;
            res_arm_reg    <= last_q;
            res_slot_reg   <= slot_reg;
        end
        else if (cmd.check)
        begin
            res_status_reg <= oob ? ST_OUT_OF_BOUNDS : (ign ? ST_IGNORED : ST_CHOSEN);
            res_arm_reg    <= arm_reg;
            res_slot_reg   <= slot_reg;
        end

        // Output register
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_arm_reg    <= res_arm_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_arm    = out_arm_reg;
    assign out_algo   = arm_algo(out_arm_reg);
    assign out_proto  = arm_proto(out_arm_reg);
    assign out_slot   = 6'(out_slot_reg);

    // The table never holds more keys than it has slots.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(KEY_SLOTS))
        else $error("key table fill beyond its depth");

    // A key is added only while a slot is free.
    a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |-> !full)
        else $error("key added to a full table");

    // A reward on an arm that was picked before is reported as applied.
    a_reward_status: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.reward && has_last) |=> (res_status_reg == ST_REWARD_APPLIED))
        else $error("reward on a known arm not reported as applied");

    // No random draw is taken while an arm of the key is untried.
    a_no_draw_untried: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick && untried && !cfg_we) |=> $stable(random_reg))
        else $error("random state moved during an untried pick");

endmodule

>>> src/ega_ctrl.sv
`timescale 1ns / 1ps

module ega_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ega_pkg::dp_stat_t stat,
    output ega_pkg::dp_cmd_t  cmd
);
    import ega_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_RD_ROW = 9'b000000100,
        S_REWARD = 9'b000001000,
        S_PICK   = 9'b000010000,
        S_DRAW2  = 9'b000100000,
        S_MEAN   = 9'b001000000,
        S_CHECK  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    mstep_t mcnt_reg;
    mstep_t mcnt_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencing of one request
    always_comb
    begin
        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search_run = 1'b1;
                if (stat.hit)
                    state_next = S_RD_ROW;
                else if (stat.miss)
                begin
                    if (stat.op_reward)
                    begin
                        cmd.set_unknown = 1'b1;
                        state_next      = S_FINISH;
                    end
                    else if (stat.full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.add    = 1'b1;
                        state_next = S_PICK;
                    end
                end
            end
            S_RD_ROW:
            begin
                cmd.row_read = 1'b1;
                state_next   = stat.op_reward ? S_REWARD : S_PICK;
            end
            S_REWARD:
            begin
                cmd.reward = 1'b1;
                state_next = S_FINISH;
            end
            S_PICK:
            begin
                cmd.pick = 1'b1;
                if (stat.untried)
                    state_next = S_CHECK;
                else if (stat.explore)
                    state_next = S_DRAW2;
                else
                begin
                    mcnt_next  = MSTEP_L_LO;
                    state_next = S_MEAN;
                end
            end
            S_DRAW2:
            begin
                cmd.draw2  = 1'b1;
                state_next = S_CHECK;
            end
            S_MEAN:
            begin
                cmd.mean_step = 1'b1;
                cmd.mean_cnt  = mcnt_reg;
                if (mcnt_reg == MSTEP_CMP)
                begin
                    mcnt_next = MSTEP_L_LO;
                    if (stat.cand_last)
                        state_next = S_CHECK;
                end
                else
                    mcnt_next = mstep_t'(mcnt_reg + 3'd1);
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mcnt_reg      <= MSTEP_L_LO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/epsilon_greedy_arm_selector_top.sv
`timescale 1ns / 1ps

// Epsilon-greedy arm selector: a table of up to KEY_SLOTS keys, three arms each.
// Requests come in on the req channel (valid/ready); op 0 selects an arm for a
// key built from coll_type, the size band of byte_count and the configured
// node and rank counts, op 1 adds a latency to the last picked arm of a key.
// Every request yields exactly one response on the rsp channel.
// Registers are written on the plain cfg port (cfg_we, cfg_index, cfg_wdata); the user writes them
// while no request is in flight, the block does not enforce this; writing the seed reloads the random generator.
// Timing: one request at a time. The key search reads one table slot per cycle.
// A select that compares means takes each compared pair through the low and high
// products of both cross terms, their accumulation and a compare, all on the single
// 32x32 multiplier.
// A response waits in an output register; the next request is accepted while
// it waits, and finishes only once the receiver has taken it.
// Reset empties the key table and restores the register defaults; no clearing
// pass is needed since a key's arm rows are written when it is added.

module epsilon_greedy_arm_selector_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ega_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ega_pkg::CFG_DATA_W-1:0] cfg_wdata,
    ega_req_if.sink                        req,
    ega_rsp_if.source                      rsp
);
    import ega_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    status_t  out_status;

    // Sequencer
    ega_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, arm statistics and result registers
    ega_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .op              (req.op),
        .coll_type       (req.coll_type),
        .byte_count      (req.byte_count),
        .reward_nodes    (req.reward_nodes),
        .reward_ranks    (req.reward_ranks),
        .latency         (req.latency),
        .arm_ignore_mask (req.arm_ignore_mask),
        .cmd             (cmd),
        .stat            (stat),
        .out_status      (out_status),
        .out_arm         (rsp.arm_index),
        .out_algo        (rsp.algo_code),
        .out_proto       (rsp.proto_code),
        .out_slot        (rsp.key_slot)
    );

    assign rsp.status = out_status;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ega_pkg::*;

    typedef struct {
        logic        op;
        logic [2:0]  coll_type;
        logic [47:0] byte_count;
        logic [15:0] reward_nodes;
        logic [15:0] reward_ranks;
        logic [31:0] latency;
        logic [2:0]  arm_ignore_mask;
    } request_t;

    typedef struct {
        logic [2:0] status;
        logic [1:0] arm_index;
        logic [2:0] algo_code;
        logic [2:0] proto_code;
        logic [5:0] key_slot;
    } answer_t;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ega_req_if req ();
    ega_rsp_if rsp ();

    epsilon_greedy_arm_selector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // Shadow copy of the selector state.
    logic [15:0] sh_nodes, sh_ranks, sh_lfsr;
    logic [16:0] sh_explore;
    logic [2:0]  sh_algo_cnt, sh_proto_cnt;
    logic [37:0] sh_keys [KEY_SLOTS];
    int          sh_fill;
    logic [31:0] sh_tries [KEY_SLOTS*3];
    logic [47:0] sh_sums [KEY_SLOTS*3];
    logic [1:0]  sh_last [KEY_SLOTS];

    answer_t pending_answers[$];
    int      errors;
    int      idle_cycles;
    int      burst_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [2:0] band_of(logic [47:0] n);
        if (n < 48'd1024) return 3'd0;
        if (n < 48'd16384) return 3'd1;
        if (n < 48'd262144) return 3'd2;
        if (n < 48'd1048576) return 3'd3;
        if (n < 48'd8388608) return 3'd4;
        return 3'd5;
    endfunction

    function automatic logic [15:0] lfsr_draw();
        sh_lfsr = sh_lfsr[0] ? ((sh_lfsr >> 1) ^ 16'hB400) : (sh_lfsr >> 1);
        return sh_lfsr;
    endfunction

    function automatic int find_slot(logic [37:0] key);
        for (int i = 0; i < sh_fill; i++)
            if (sh_keys[i] == key)
                return i;
        return -1;
    endfunction

    function automatic answer_t make_answer(status_t st, logic [1:0] arm, int slot);
        answer_t a;
        a.status = st;
        a.arm_index = arm;
        a.algo_code = (arm == 2'd2) ? 3'd1 : 3'd0;
        a.proto_code = (arm == 2'd0 || arm == 2'd2) ? 3'd2 : (arm == 2'd1 ? 3'd1 : 3'd0);
        a.key_slot = slot[5:0];
        return a;
    endfunction

    // Predict the response to one request and update the shadow state.
    function automatic answer_t predict_answer(request_t r);
        logic [37:0] key;
        int          slot, idx;
        logic [1:0]  arm;
        logic [48:0] sum;
        logic [79:0] lhs, rhs;
        logic [2:0]  algo, proto;
        if (r.op == OP_REWARD)
        begin
            key = {r.coll_type, band_of(r.byte_count), r.reward_nodes, r.reward_ranks};
            slot = find_slot(key);
            if (slot < 0)
                return make_answer(ST_UNKNOWN_KEY, NO_ARM, 0);
            arm = sh_last[slot];
            if (arm == NO_ARM)
                return make_answer(ST_NO_LAST_ARM, NO_ARM, slot);
            idx = slot * 3 + arm;
            if (sh_tries[idx] != 32'hFFFF_FFFF)
                sh_tries[idx] = sh_tries[idx] + 1;
            sum = {1'b0, sh_sums[idx]} + r.latency;
            sh_sums[idx] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
            return make_answer(ST_REWARD_APPLIED, arm, slot);
        end
        key = {r.coll_type, band_of(r.byte_count), sh_nodes, sh_ranks};
        slot = find_slot(key);
        if (slot < 0)
        begin
            if (sh_fill >= KEY_SLOTS)
                return make_answer(ST_TABLE_FULL, NO_ARM, 0);
            slot = sh_fill;
            sh_fill++;
            sh_keys[slot] = key;
            sh_last[slot] = NO_ARM;
            for (int i = 0; i < 3; i++)
            begin
                sh_tries[slot*3+i] = '0;
                sh_sums[slot*3+i] = '0;
            end
        end
        if (sh_tries[slot*3] == 0) arm = 2'd0;
        else if (sh_tries[slot*3+1] == 0) arm = 2'd1;
        else if (sh_tries[slot*3+2] == 0) arm = 2'd2;
        else if ({1'b0, lfsr_draw()} < sh_explore) arm = 2'(lfsr_draw() % 3);
        else
        begin
            arm = 2'd0;
            for (int i = 1; i < 3; i++)
            begin
                lhs = sh_sums[slot*3+i] * sh_tries[slot*3+arm];
                rhs = sh_sums[slot*3+arm] * sh_tries[slot*3+i];
                if (lhs < rhs)
                    arm = 2'(i);
            end
        end
        algo = (arm == 2'd2) ? 3'd1 : 3'd0;
        proto = (arm == 2'd1) ? 3'd1 : 3'd2;
        if (algo >= sh_algo_cnt || proto >= sh_proto_cnt)
            return make_answer(ST_OUT_OF_BOUNDS, arm, slot);
        if (r.arm_ignore_mask[arm])
            return make_answer(ST_IGNORED, arm, slot);
        sh_last[slot] = arm;
        return make_answer(ST_CHOSEN, arm, slot);
    endfunction

    // Check each response against the oldest prediction.
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response, expected none, actual status %0d",
                         $time, rsp.status);
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (rsp.status !== exp_a.status || rsp.arm_index !== exp_a.arm_index ||
                    rsp.algo_code !== exp_a.algo_code ||
                    rsp.proto_code !== exp_a.proto_code ||
                    rsp.key_slot !== exp_a.key_slot)
                begin
                    errors++;
                    $display("%0t: mismatch expected st=%0d arm=%0d algo=%0d proto=%0d slot=%0d",
                             $time, exp_a.status, exp_a.arm_index, exp_a.algo_code,
                             exp_a.proto_code, exp_a.key_slot);
                    $display("%0t:          actual   st=%0d arm=%0d algo=%0d proto=%0d slot=%0d",
                             $time, rsp.status, rsp.arm_index, rsp.algo_code,
                             rsp.proto_code, rsp.key_slot);
                end
            end
        end
    end

    // Receiver stalls on a cycling pattern with calm stretches.
    always @(negedge clk)
    begin
        int phase;
        phase = ($time / 10) % 400;
        if (phase < 80)
            rsp.ready <= 1'b1;
        else if (phase < 240)
            rsp.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp.ready <= ($urandom_range(0, 2) == 0);
    end

    // Watchdog on cycles without any accepted request or response.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Valid stays high between requests of a burst and drops at a gap.
    task automatic send_request(request_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 80);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req.valid <= 1'b1;
        req.op <= r.op;
        req.coll_type <= r.coll_type;
        req.byte_count <= r.byte_count;
        req.reward_nodes <= r.reward_nodes;
        req.reward_ranks <= r.reward_ranks;
        req.latency <= r.latency;
        req.arm_ignore_mask <= r.arm_ignore_mask;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_answers.push_back(predict_answer(r));
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [16:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_LOCAL_NODES: sh_nodes = value[15:0];
            CFG_LOCAL_RANKS: sh_ranks = value[15:0];
            CFG_EXPLORE:     sh_explore = value;
            CFG_ALGO_COUNT:  sh_algo_cnt = value[2:0];
            CFG_PROTO_COUNT: sh_proto_cnt = value[2:0];
            default:
            begin
                sh_lfsr = (value[15:0] == 0) ? 16'd1 : value[15:0];
            end
        endcase
    endtask

    function automatic logic [47:0] random_bytes();
        case ($urandom_range(0, 7))
            0: return 48'($urandom_range(0, 1100));
            1: return 48'($urandom_range(15000, 17000));
            2: return 48'($urandom_range(250000, 270000));
            3: return 48'($urandom_range(1040000, 1060000));
            4: return 48'($urandom_range(8380000, 8400000));
            5: return {$urandom(), 16'($urandom())};
            default: return 48'($urandom_range(0, 20000000));
        endcase
    endfunction

    function automatic request_t select_req(logic [2:0] ct, logic [47:0] n, logic [2:0] mask);
        request_t r;
        r = '{OP_SELECT, ct, n, 16'($urandom()), 16'($urandom()), $urandom(), mask};
        return r;
    endfunction

    function automatic request_t reward_req(logic [2:0] ct, logic [47:0] n, logic [31:0] lat);
        request_t r;
        r = '{OP_REWARD, ct, n, sh_nodes, sh_ranks, lat, 3'($urandom())};
        return r;
    endfunction

    // Band edges, arm walk, unknown key, missing last arm, largest latencies.
    task automatic test_directed();
        logic [47:0] edges [12] = '{0, 1023, 1024, 16383, 16384, 262143, 262144,
                                    1048575, 1048576, 8388607, 8388608, 48'hFFFF_FFFF_FFFF};
        send_request(reward_req(3'd0, 0, 32'd5));
        send_request(select_req(3'd0, 0, 3'b001));
        send_request(reward_req(3'd0, 0, 32'd5));
        for (int i = 0; i < 12; i++)
            send_request(select_req(3'(i), edges[i], 3'b000));
        for (int i = 0; i < 4; i++)
        begin
            send_request(select_req(3'd7, 48'hFFFF_FFFF_FFFF, 3'b000));
            send_request(reward_req(3'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        end
        send_request(select_req(3'd0, 0, 3'b111));
        drain();
    endtask

    // Learning loops on few keys, mixed with fully random requests.
    task automatic test_random(int count, int keys);
        request_t    r;
        logic [2:0]  ct;
        logic [47:0] n;
        for (int i = 0; i < count; i++)
        begin
            ct = 3'($urandom_range(0, keys - 1));
            n = ($urandom_range(0, 3) == 0) ? random_bytes() : 48'(ct) * 48'd5000;
            if ($urandom_range(0, 9) == 0)
                r = '{1'($urandom()), 3'($urandom()), random_bytes(), 16'($urandom()),
                      16'($urandom()), $urandom(), 3'($urandom())};
            else if ($urandom_range(0, 1) == 0)
                r = select_req(ct, n, ($urandom_range(0, 3) == 0) ? 3'($urandom()) : 3'd0);
            else
                r = reward_req(ct, n, ($urandom_range(0, 20) == 0) ? $urandom()
                               : 32'($urandom_range(1000, 400000 + ct * 20000)));
            send_request(r);
        end
        drain();
    endtask

    // Fill the table and go past it.
    task automatic test_table_full();
        for (int i = 0; i < 72; i++)
        begin
            write_reg(CFG_LOCAL_NODES, 17'(i + 100));
            send_request(select_req(3'($urandom()), random_bytes(), 3'($urandom())));
            drain();
        end
        test_random(150, 8);
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.op = 1'b0;
        req.coll_type = '0;
        req.byte_count = '0;
        req.reward_nodes = '0;
        req.reward_ranks = '0;
        req.latency = '0;
        req.arm_ignore_mask = '0;
        rsp.ready = 1'b0;
        sh_nodes = 16'd1;
        sh_ranks = 16'd1;
        sh_explore = 17'd6554;
        sh_algo_cnt = 3'd7;
        sh_proto_cnt = 3'd3;
        sh_lfsr = 16'd44257;
        sh_fill = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(400, 4);
        write_reg(CFG_EXPLORE, 17'd65536);
        write_reg(CFG_LFSR_SEED, 17'd0);
        write_reg(CFG_ALGO_COUNT, 17'd0);
        write_reg(CFG_PROTO_COUNT, 17'd7);
        test_random(150, 4);
        write_reg(CFG_EXPLORE, 17'd0);
        write_reg(CFG_ALGO_COUNT, 17'd1);
        write_reg(CFG_PROTO_COUNT, 17'd2);
        write_reg(CFG_LOCAL_RANKS, 17'hFFFF);
        write_reg(CFG_LOCAL_NODES, 17'h0);
        test_random(250, 3);
        write_reg(CFG_EXPLORE, 17'd20000);
        write_reg(CFG_LFSR_SEED, 17'hFFFF);
        write_reg(CFG_ALGO_COUNT, 17'd7);
        write_reg(CFG_PROTO_COUNT, 17'd3);
        write_reg(CFG_LOCAL_NODES, 17'hFFFF);
        write_reg(CFG_LOCAL_RANKS, 17'h0);
        test_random(350, 6);
        test_table_full();

        if (errors == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
src/ega_pkg.sv
src/ega_ifs.sv
src/ega_datapath.sv
src/ega_ctrl.sv
src/epsilon_greedy_arm_selector_top.sv
sim/testbench.sv
